/* hdl/smc_pkg.sv */
package smc_pkg;

  // operating modes
  typedef enum logic [1:0] {
    M_NORMAL  = 2'd0,
    M_STANDBY = 2'd1,
    M_HIB     = 2'd2
  } mode_t;

  // payload identifiers
  typedef enum logic [1:0] {
    P_NONE = 2'd0,
    P_EDC0 = 2'd1,
    P_EDC1 = 2'd2,
    P_EXP  = 2'd3
  } pl_id_t;

  // command codes on the result channel
  typedef enum logic [2:0] {
    CMD_STATUS    = 3'd0,
    CMD_SET_MODE  = 3'd1,
    CMD_PL_ENABLE = 3'd2,
    CMD_PL_DIS    = 3'd3,
    CMD_EDC_STOP  = 3'd4,
    CMD_PX_START  = 3'd5,
    CMD_EDC_KICK  = 3'd6
  } cmd_kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_EDC_SEL    = 2'd0,
    CFG_HIB_DUR    = 2'd1,
    CFG_EXP_PERIOD = 2'd2
  } cfg_index_t;

  localparam int STEP_N = 14;
  typedef logic [STEP_N-1:0] step_mask_t;

  // sequencer steps, in the order they run for one item
  typedef enum logic [STEP_N-1:0] {
    S_IDLE       = 14'h0001,
    S_ENTER      = 14'h0002,
    S_LEAVE      = 14'h0004,
    S_ZIN_MODE   = 14'h0008,
    S_ZIN_EN     = 14'h0010,
    S_ZOUT_STOP  = 14'h0020,
    S_ZOUT_DIS   = 14'h0040,
    S_ZOUT_EN    = 14'h0080,
    S_ZOUT_START = 14'h0100,
    S_EXP_MODE   = 14'h0200,
    S_EXP_DIS    = 14'h0400,
    S_TIMEOUT    = 14'h0800,
    S_KICK       = 14'h1000,
    S_STATUS     = 14'h2000
  } step_t;

  // classified item handed from front to back
  typedef struct packed {
    step_mask_t  steps;
    logic [31:0] now_time;
    logic        px_ok;
  } plan_t;

endpackage

/* hdl/smc_if.sv */
interface smc_in_if import smc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [4:0]  event_flags;
  logic [31:0] now_time;
  logic        px_enable_ok;

  modport source (output valid, event_flags, now_time, px_enable_ok, input ready);
  modport sink (input valid, event_flags, now_time, px_enable_ok, output ready);
endinterface

interface smc_out_if import smc_pkg::*; ();
  logic        valid;
  logic        ready;
  cmd_kind_t   cmd_kind;
  logic [31:0] cmd_arg;
  mode_t       cur_mode;
  pl_id_t      cur_payload;
  logic        zone_flag;
  logic        hib_flag;
  logic        last;

  modport source (output valid, cmd_kind, cmd_arg, cur_mode, cur_payload, zone_flag,
                  hib_flag, last, input ready);
  modport sink (input valid, cmd_kind, cmd_arg, cur_mode, cur_payload, zone_flag,
                hib_flag, last, output ready);
endinterface

interface smc_cfg_if import smc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* hdl/smc_front.sv */
module smc_front import smc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  smc_in_if.sink events,
  output plan_t  plan,
  output logic   plan_valid,
  input  logic   plan_pop
);

  plan_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  plan_t      incoming;
  step_mask_t steps;

  // classify: turn the event flags into the list of steps the back runs
  always_comb begin
    steps = S_TIMEOUT | S_KICK | S_STATUS;
    if (events.event_flags[0]) begin
      steps = steps | S_ENTER;
    end
    if (events.event_flags[1]) begin
      steps = steps | S_LEAVE;
    end
    if (events.event_flags[2]) begin
      steps = steps | S_ZIN_MODE | S_ZIN_EN;
    end
    if (events.event_flags[3]) begin
      steps = steps | S_ZOUT_STOP | S_ZOUT_DIS | S_ZOUT_EN | S_ZOUT_START;
    end
    if (events.event_flags[4]) begin
      steps = steps | S_EXP_MODE | S_EXP_DIS;
    end
    incoming.steps    = steps;
    incoming.now_time = events.now_time;
    incoming.px_ok    = events.px_enable_ok;
  end

  assign events.ready = (count != 2'd2);
  assign push         = events.valid && events.ready;
  assign plan         = slots[rd_ptr];
  assign plan_valid   = (count != 2'd0);

  // two-entry item queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (plan_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(plan_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

endmodule

/* hdl/smc_back.sv */
module smc_back import smc_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  plan_t     plan,
  input  logic      plan_valid,
  output logic      plan_pop,
  smc_cfg_if.sink   cfg,
  smc_out_if.source cmds
);

  // configuration
  logic        edc_sel;
  logic [31:0] hib_dur;
  logic [31:0] exp_period;

  // controller state
  step_t                 state;
  step_t                 state_next;
  mode_t                 mode;
  mode_t                 mode_next;
  logic [TIME_WIDTH-1:0] mode_change_time;
  logic [TIME_WIDTH-1:0] mode_change_time_next;
  pl_id_t                payload;
  pl_id_t                payload_next;
  logic                  in_zone;
  logic                  in_zone_next;
  logic                  edc_on;
  logic                  edc_on_next;
  logic                  hib;
  logic                  hib_next;
  logic                  zone_exit;
  logic                  zone_exit_next;

  // output register
  logic        out_valid;
  cmd_kind_t   out_kind;
  logic [31:0] out_arg;
  mode_t       out_mode;
  pl_id_t      out_payload;
  logic        out_zone;
  logic        out_hib;
  logic        out_last;

  logic                  emit;
  cmd_kind_t             kind;
  logic [31:0]           arg;
  logic                  last_flag;
  logic                  slot_free;
  logic                  adv;
  mode_t                 wake;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] deadline;
  step_mask_t            later;
  step_mask_t            cand;
  step_mask_t            first;

  assign cfg.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      edc_sel    <= 1'b0;
      hib_dur    <= 32'd0;
      exp_period <= 32'd0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_EDC_SEL:    edc_sel    <= cfg.data[0];
        CFG_HIB_DUR:    hib_dur    <= cfg.data;
        CFG_EXP_PERIOD: exp_period <= cfg.data;
        default: ;
      endcase
    end
  end

  assign now_t    = TIME_WIDTH'(plan.now_time);
  assign deadline = mode_change_time + TIME_WIDTH'(hib_dur);
  assign wake     = (in_zone || payload == P_EXP) ? M_NORMAL : M_STANDBY;

  // one step: state update and the command it emits
  always_comb begin
    mode_next             = mode;
    mode_change_time_next = mode_change_time;
    payload_next          = payload;
    in_zone_next          = in_zone;
    edc_on_next           = edc_on;
    hib_next              = hib;
    zone_exit_next        = zone_exit;
    emit                  = 1'b0;
    kind                  = CMD_STATUS;
    arg                   = 32'd0;
    last_flag             = 1'b0;
    unique case (state)
      S_IDLE: ;
      S_ENTER: begin
        hib_next              = 1'b1;
        mode_next             = M_HIB;
        mode_change_time_next = now_t;
        emit                  = 1'b1;
        kind                  = CMD_SET_MODE;
        arg                   = 32'(M_HIB);
      end
      S_LEAVE: begin
        hib_next              = 1'b0;
        mode_next             = wake;
        mode_change_time_next = now_t;
        emit                  = 1'b1;
        kind                  = CMD_SET_MODE;
        arg                   = 32'(wake);
      end
      S_ZIN_MODE: begin
        if (!hib) begin
          mode_next             = M_NORMAL;
          mode_change_time_next = now_t;
          emit                  = 1'b1;
          kind                  = CMD_SET_MODE;
          arg                   = 32'(M_NORMAL);
        end
      end
      S_ZIN_EN: begin
        if (!in_zone) begin
          in_zone_next = 1'b1;
          payload_next = edc_sel ? P_EDC1 : P_EDC0;
          edc_on_next  = 1'b1;
          emit         = 1'b1;
          kind         = CMD_PL_ENABLE;
          arg          = 32'(payload_next);
        end
      end
      S_ZOUT_STOP: begin
        edc_on_next = 1'b0;
        emit        = 1'b1;
        kind        = CMD_EDC_STOP;
      end
      S_ZOUT_DIS: begin
        emit = 1'b1;
        kind = CMD_PL_DIS;
        arg  = 32'(payload);
      end
      S_ZOUT_EN: begin
        zone_exit_next = in_zone;
        if (in_zone) begin
          in_zone_next = 1'b0;
          payload_next = P_EXP;
          emit         = 1'b1;
          kind         = CMD_PL_ENABLE;
          arg          = 32'(P_EXP);
        end
      end
      S_ZOUT_START: begin
        if (zone_exit && plan.px_ok) begin
          emit = 1'b1;
          kind = CMD_PX_START;
          arg  = exp_period;
        end
      end
      S_EXP_MODE: begin
        if (!hib) begin
          mode_next             = M_STANDBY;
          mode_change_time_next = now_t;
          emit                  = 1'b1;
          kind                  = CMD_SET_MODE;
          arg                   = 32'(M_STANDBY);
        end
      end
      S_EXP_DIS: begin
        // disable goes out with the old payload, then it is cleared silently
        emit = 1'b1;
        kind = CMD_PL_DIS;
        arg  = 32'(payload);
      end
      S_TIMEOUT: begin
        if (mode == M_HIB && deadline <= now_t) begin
          hib_next              = 1'b0;
          mode_next             = wake;
          mode_change_time_next = now_t;
          emit                  = 1'b1;
          kind                  = CMD_SET_MODE;
          arg                   = 32'(wake);
        end
      end
      S_KICK: begin
        if (in_zone && edc_on) begin
          emit = 1'b1;
          kind = CMD_EDC_KICK;
        end
      end
      S_STATUS: begin
        emit      = 1'b1;
        kind      = CMD_STATUS;
        last_flag = 1'b1;
      end
      default: ;
    endcase
  end

  // next step: lowest enabled step above the current one
  assign later = ~((step_mask_t'(state) << 1) - step_mask_t'(1));
  assign cand  = plan.steps & later;
  assign first = cand & (~cand + step_mask_t'(1));

  assign slot_free = !out_valid || cmds.ready;
  assign adv       = (state == S_IDLE) ? plan_valid : (!emit || slot_free);
  assign plan_pop  = (state == S_STATUS) && adv;

  always_comb begin
    state_next = state;
    if (adv) begin
      state_next = (state == S_STATUS) ? S_IDLE : step_t'(first);
    end
  end

  // sequencer and controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      mode             <= M_NORMAL;
      mode_change_time <= '0;
      payload          <= P_NONE;
      in_zone          <= 1'b0;
      edc_on           <= 1'b0;
      hib              <= 1'b0;
      zone_exit        <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) begin
        mode             <= mode_next;
        mode_change_time <= mode_change_time_next;
        payload          <= (state == S_EXP_DIS) ? P_NONE : payload_next;
        in_zone          <= in_zone_next;
        edc_on           <= edc_on_next;
        hib              <= hib_next;
        zone_exit        <= zone_exit_next;
      end
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && emit) begin
      out_valid <= 1'b1;
    end else if (cmds.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload, snapshot after the step
  always_ff @(posedge clk) begin
    if (adv && emit) begin
      out_kind    <= kind;
      out_arg     <= arg;
      out_mode    <= mode_next;
      out_payload <= payload_next;
      out_zone    <= in_zone_next;
      out_hib     <= hib_next;
      out_last    <= last_flag;
    end
  end

  assign cmds.valid       = out_valid;
  assign cmds.cmd_kind    = out_kind;
  assign cmds.cmd_arg     = out_arg;
  assign cmds.cur_mode    = out_mode;
  assign cmds.cur_payload = out_payload;
  assign cmds.zone_flag   = out_zone;
  assign cmds.hib_flag    = out_hib;
  assign cmds.last        = out_last;

  // hibernation request and hibernation mode move together
  a_hib_mode: assert property (@(posedge clk) disable iff (rst)
    hib == (mode == M_HIB))
    else $error("hibernation flag and mode disagree");

  // edc is only active inside the zone
  a_edc_zone: assert property (@(posedge clk) disable iff (rst)
    edc_on |-> in_zone)
    else $error("edc active outside zone");

  // an item leaves the queue only with its final status item loaded
  a_pop_last: assert property (@(posedge clk) disable iff (rst)
    plan_pop |=> (out_valid && out_last && out_kind == CMD_STATUS))
    else $error("item retired without status");

  // the head item stays present while its steps run
  a_busy_head: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> plan_valid)
    else $error("sequencer running without an item");

endmodule

/* hdl/satellite_mode_controller_top.sv */
// Mode controller: each item on events is one control period and yields an
// ordered run of commands on cmds, closed by a status item with last set.
// The front takes items into a two-entry queue whenever it has room, so
// the next period can be accepted while commands are still going out. The
// back runs one step per cycle through the steps the event flags enable,
// plus the hibernation timeout, edc kick and status steps, and picks each
// item up from its idle step; a step that emits a command waits while cmds
// holds ready low with the output register still full.
// Configuration writes on cfg are always ready and take effect next cycle.
module satellite_mode_controller_top import smc_pkg::*; #(
  parameter int TIME_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  smc_in_if.sink    events,
  smc_out_if.source cmds,
  smc_cfg_if.sink   cfg
);

  plan_t plan;
  logic  plan_valid;
  logic  plan_pop;

  // item intake and classification
  smc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .events     (events),
    .plan       (plan),
    .plan_valid (plan_valid),
    .plan_pop   (plan_pop)
  );

  // command sequencer and controller state
  smc_back #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .plan       (plan),
    .plan_valid (plan_valid),
    .plan_pop   (plan_pop),
    .cfg        (cfg),
    .cmds       (cmds)
  );

endmodule

/* sim/satellite_mode_controller_top_tb.sv */
`timescale 1ns / 100ps

module satellite_mode_controller_top_tb;
  import smc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 250;
  localparam int unsigned TAIL_CYCLES = 20;

  // one control period on the event channel
  typedef struct {
    logic [4:0]  flags;
    logic [31:0] now;
    logic        px_ok;
  } period_t;

  // one command on the result channel
  typedef struct {
    cmd_kind_t   kind;
    logic [31:0] arg;
    mode_t       mode;
    pl_id_t      payload;
    logic        zone;
    logic        hib;
    logic        last;
  } cmd_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  smc_in_if  ev_if();
  smc_out_if cmd_if();
  smc_cfg_if cfg_if();

  satellite_mode_controller_top #(.TIME_WIDTH(32)) DUT (
    .clk    (clk),
    .rst    (rst),
    .events (ev_if),
    .cmds   (cmd_if),
    .cfg    (cfg_if)
  );

  always #5 clk = ~clk;

  period_t     period_q[$];
  cmd_item_t   cmd_q[$];
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_req = 0;
  bit          ev_taken = 0;
  logic [31:0] t_now;

  // controller state and register copies
  mode_t       mode_st;
  logic [31:0] mode_time_st;
  pl_id_t      payload_st;
  logic        zone_st;
  logic        edc_st;
  logic        hib_st;
  logic        edc_sel_cfg;
  logic [31:0] hib_dur_cfg;
  logic [31:0] exp_period_cfg;

  // record a command with the state as it stands after it
  function automatic void push_cmd(cmd_kind_t kind, logic [31:0] arg, logic last);
    cmd_item_t c;
    c.kind    = kind;
    c.arg     = arg;
    c.mode    = mode_st;
    c.payload = payload_st;
    c.zone    = zone_st;
    c.hib     = hib_st;
    c.last    = last;
    cmd_q.push_back(c);
  endfunction

  function automatic void set_mode_to(mode_t m, logic [31:0] t);
    mode_st      = m;
    mode_time_st = t;
    push_cmd(CMD_SET_MODE, 32'(m), 1'b0);
  endfunction

  function automatic mode_t wake_mode();
    return (zone_st || payload_st == P_EXP) ? M_NORMAL : M_STANDBY;
  endfunction

  // commands caused by one control period, in emission order
  function automatic void control_period(period_t p);
    logic [31:0] deadline;
    if (p.flags[0]) begin
      hib_st = 1'b1;
      set_mode_to(M_HIB, p.now);
    end
    if (p.flags[1]) begin
      hib_st = 1'b0;
      set_mode_to(wake_mode(), p.now);
    end
    if (p.flags[2]) begin
      if (!hib_st) set_mode_to(M_NORMAL, p.now);
      if (!zone_st) begin
        zone_st    = 1'b1;
        payload_st = edc_sel_cfg ? P_EDC1 : P_EDC0;
        edc_st     = 1'b1;
        push_cmd(CMD_PL_ENABLE, 32'(payload_st), 1'b0);
      end
    end
    if (p.flags[3]) begin
      edc_st = 1'b0;
      push_cmd(CMD_EDC_STOP, 32'd0, 1'b0);
      push_cmd(CMD_PL_DIS, 32'(payload_st), 1'b0);
      if (zone_st) begin
        zone_st    = 1'b0;
        payload_st = P_EXP;
        push_cmd(CMD_PL_ENABLE, 32'(P_EXP), 1'b0);
        if (p.px_ok) push_cmd(CMD_PX_START, exp_period_cfg, 1'b0);
      end
    end
    if (p.flags[4]) begin
      if (!hib_st) set_mode_to(M_STANDBY, p.now);
      push_cmd(CMD_PL_DIS, 32'(payload_st), 1'b0);
      payload_st = P_NONE;
    end
    // hibernation timeout, sum wraps at 32 bits
    deadline = mode_time_st + hib_dur_cfg;
    if (mode_st == M_HIB && deadline <= p.now) begin
      hib_st = 1'b0;
      set_mode_to(wake_mode(), p.now);
    end
    if (zone_st && edc_st) push_cmd(CMD_EDC_KICK, 32'd0, 1'b0);
    push_cmd(CMD_STATUS, 32'd0, 1'b1);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // sample handshakes, keep the predictor, check commands
  always @(posedge clk) begin
    cmd_item_t c;
    cycle_cnt++;
    ev_taken = 1'b0;
    if (rst) begin
      mode_st        = M_NORMAL;
      mode_time_st   = '0;
      payload_st     = P_NONE;
      zone_st        = 1'b0;
      edc_st         = 1'b0;
      hib_st         = 1'b0;
      edc_sel_cfg    = 1'b0;
      hib_dur_cfg    = '0;
      exp_period_cfg = '0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        case (cfg_index_t'(cfg_if.index))
          CFG_EDC_SEL:    edc_sel_cfg    = cfg_if.data[0];
          CFG_HIB_DUR:    hib_dur_cfg    = cfg_if.data;
          CFG_EXP_PERIOD: exp_period_cfg = cfg_if.data;
          default: ;
        endcase
      end
      if (ev_if.valid && ev_if.ready) begin
        control_period('{ev_if.event_flags, ev_if.now_time, ev_if.px_enable_ok});
        n_taken++;
        ev_taken = 1'b1;
      end
      if (cmd_if.valid && cmd_if.ready) begin
        if (cmd_q.size() == 0) begin
          $error("cmd_kind: no command pending, actual %0d", cmd_if.cmd_kind);
          err_cnt++;
        end else begin
          c = cmd_q.pop_front();
          check_field("cmd_kind", 32'(c.kind), 32'(cmd_if.cmd_kind));
          check_field("cmd_arg", c.arg, cmd_if.cmd_arg);
          check_field("cur_mode", 32'(c.mode), 32'(cmd_if.cur_mode));
          check_field("cur_payload", 32'(c.payload), 32'(cmd_if.cur_payload));
          check_field("zone_flag", 32'(c.zone), 32'(cmd_if.zone_flag));
          check_field("hib_flag", 32'(c.hib), 32'(cmd_if.hib_flag));
          check_field("last", 32'(c.last), 32'(cmd_if.last));
        end
      end
    end
  end

  // long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left <= HOLD_CYCLES;
      hold_req = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // event driver, fed from the period queue
  always @(negedge clk) begin
    period_t nxt;
    if (rst) begin
      ev_if.valid <= 1'b0;
    end else if (!ev_if.valid || ev_taken) begin
      if (period_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = period_q.pop_front();
        ev_if.event_flags  <= nxt.flags;
        ev_if.now_time     <= nxt.now;
        ev_if.px_enable_ok <= nxt.px_ok;
        ev_if.valid        <= 1'b1;
      end else begin
        ev_if.valid <= 1'b0;
      end
    end
  end

  // command receiver
  always @(negedge clk) begin
    if (rst) begin
      cmd_if.ready <= 1'b0;
    end else begin
      cmd_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic queue_period(logic [4:0] flags, logic [31:0] now, logic px_ok);
    period_q.push_back('{flags, now, px_ok});
    n_queued++;
  endtask

  // single events, no events or random flag sets; mostly advancing time, some full-range noise
  task automatic queue_random(int unsigned count);
    logic [4:0]  flags;
    logic [31:0] now;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: flags = 5'(1 << $urandom_range(4));
        4:          flags = '0;
        default:    flags = 5'($urandom_range(31));
      endcase
      t_now = t_now + $urandom_range(0, 20);
      now   = ($urandom_range(9) == 0) ? $urandom : t_now;
      queue_period(flags, now, 1'($urandom_range(1)));
    end
  endtask

  task automatic wait_idle();
    while (n_taken != n_queued || cmd_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(int unsigned idle_pct, int unsigned stall_pct,
                              logic [31:0] dur);
    write_reg(CFG_EDC_SEL, $urandom);
    write_reg(CFG_HIB_DUR, dur);
    write_reg(CFG_EXP_PERIOD, $urandom);
    @(posedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    t_now = $urandom;
    queue_random(24);
    wait_idle();
  endtask

  initial begin
    ev_if.valid        = 1'b0;
    ev_if.event_flags  = '0;
    ev_if.now_time     = '0;
    ev_if.px_enable_ok = 1'b0;
    cmd_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: edc0 main with upper bits set, short hibernation
    write_reg(CFG_EDC_SEL, 32'hFFFF_FFFE);
    write_reg(CFG_HIB_DUR, 32'd10);
    write_reg(CFG_EXP_PERIOD, 32'hFFFF_FFFF);
    @(posedge clk);
    queue_period(5'b00000, 32'd0, 1'b0);
    queue_period(5'b00100, 32'd1, 1'b1);
    // repeated zone entry sets the same mode again
    queue_period(5'b00100, 32'd2, 1'b0);
    queue_period(5'b01000, 32'd3, 1'b1);
    // zone exit while already out
    queue_period(5'b01000, 32'd4, 1'b1);
    queue_period(5'b10000, 32'd5, 1'b0);
    // experiment done with no payload active
    queue_period(5'b10000, 32'd6, 1'b0);
    queue_period(5'b00001, 32'd100, 1'b0);
    queue_period(5'b00000, 32'd105, 1'b0);
    queue_period(5'b00000, 32'd110, 1'b0);
    queue_period(5'b00011, 32'd200, 1'b0);
    queue_period(5'b00101, 32'd300, 1'b1);
    queue_period(5'b10000, 32'd305, 1'b0);
    queue_period(5'b00010, 32'd306, 1'b0);
    queue_period(5'b01000, 32'd307, 1'b0);
    queue_period(5'b11111, 32'hFFFF_FFFF, 1'b1);
    queue_period(5'b11111, 32'd0, 1'b0);
    // deadline wraps past zero and expires at once
    queue_period(5'b00001, 32'hFFFF_FFF8, 1'b0);
    queue_period(5'b00000, 32'd0, 1'b1);
    wait_idle();

    // directed: edc1 main, longest hibernation, zero period
    write_reg(CFG_EDC_SEL, 32'h8000_0001);
    write_reg(CFG_HIB_DUR, 32'hFFFF_FFFF);
    write_reg(CFG_EXP_PERIOD, 32'd0);
    @(posedge clk);
    queue_period(5'b00100, 32'd1000, 1'b0);
    queue_period(5'b00001, 32'd1000, 1'b0);
    queue_period(5'b01001, 32'd5, 1'b1);
    wait_idle();
    write_reg(CFG_HIB_DUR, 32'd0);
    @(posedge clk);
    queue_period(5'b00001, 32'd0, 1'b0);
    queue_period(5'b00101, 32'd7, 1'b1);
    wait_idle();

    // random phases with different idling
    random_phase(0, 0, $urandom_range(0, 40));
    random_phase(53, 0, $urandom_range(0, 40));
    random_phase(0, 53, $urandom_range(0, 40));
    random_phase(14, 14, $urandom);

    // receiver holds off while periods keep coming
    write_reg(CFG_HIB_DUR, $urandom_range(0, 40));
    @(negedge clk);
    hold_req = 1'b1;
    @(posedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(12);
    wait_idle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (cmd_q.size() != 0) begin
      $error("cmd_kind: %0d commands never arrived", cmd_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
